// ----- hw/rtl/rmj_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared widths and constants of the radar measurement Jacobian datapath.
// ----------------------------------------------------------------------------
package rmj_pkg;

  // Width of every item field and of every result entry.
  localparam int DATA_W = 32;
  // Width of the squared range and of the velocity cross term magnitude.
  localparam int WIDE_W = 64;
  // Width of the 64 x 32 bit products.
  localparam int PROD_W = 96;
  // Square root stages, one result bit each.
  localparam int SQRT_STAGES = 32;
  // Quotient bits taken from each divider (rounding bit included).
  localparam int QUO_W = 34;

  // Saturation bounds of a result entry.
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ----- hw/rtl/rmj_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_in_if
// Input channel: one constant-velocity state per item.
// ----------------------------------------------------------------------------
interface rmj_in_if;
  import rmj_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;

  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                output ready);
endinterface

// ----- hw/rtl/rmj_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_out_if
// Result channel: the six distinct Jacobian entries and a validity flag.
// ----------------------------------------------------------------------------
interface rmj_out_if;
  import rmj_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_dx;
  logic signed [DATA_W-1:0] range_dy;
  logic signed [DATA_W-1:0] bearing_dx;
  logic signed [DATA_W-1:0] bearing_dy;
  logic signed [DATA_W-1:0] rate_dx;
  logic signed [DATA_W-1:0] rate_dy;
  logic                     valid_res;

  modport source (output valid, output range_dx, output range_dy, output bearing_dx,
                  output bearing_dy, output rate_dx, output rate_dy, output valid_res,
                  input ready);
  modport sink (input valid, input range_dx, input range_dy, input bearing_dx,
                input bearing_dy, input rate_dx, input rate_dy, input valid_res,
                output ready);
endinterface

// ----- hw/rtl/rmj_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_cfg_if
// Configuration write channel carrying the minimum squared range.
// ----------------------------------------------------------------------------
interface rmj_cfg_if;
  import rmj_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rmj_dly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_dly
// Enable-gated delay line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module rmj_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] pipe_q [N];

  // Shift the whole line whenever the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= data_i;
      for (int k = 1; k < N; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign data_o = pipe_q[N-1];

endmodule

// ----- hw/rtl/rmj_wmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_wmul
// Two-stage 64 x 32 bit unsigned multiplier built from two 32 x 32 products.
// ----------------------------------------------------------------------------
module rmj_wmul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rmj_pkg::WIDE_W-1:0]  a_i,
  input  logic [rmj_pkg::DATA_W-1:0]  b_i,
  output logic [rmj_pkg::PROD_W-1:0]  p_o
);
  import rmj_pkg::*;

  logic [WIDE_W-1:0] lo_d, hi_d, lo_q, hi_q;
  logic [PROD_W-1:0] p_d, p_q;

  // First stage: partial products of the low and high halves.
  assign lo_d = a_i[DATA_W-1:0] * b_i;
  assign hi_d = a_i[WIDE_W-1:DATA_W] * b_i;

  // Second stage: align and add the partial products.
  assign p_d = {{DATA_W{1'b0}}, lo_q} + {hi_q, {DATA_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/rmj_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_isqrt
// Pipelined integer square root: floor(sqrt(x)), one root bit per stage.
// ----------------------------------------------------------------------------
module rmj_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rmj_pkg::WIDE_W-1:0]  x_i,
  output logic [rmj_pkg::DATA_W-1:0]  root_o
);
  import rmj_pkg::*;

  localparam int REM_W = DATA_W + 2;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DATA_W-1:0] root;
    logic [WIDE_W-1:0] xs;
  } sq_stage_t;

  sq_stage_t stage_q [SQRT_STAGES];

  // One digit step: bring down two radicand bits and try the next root bit.
  function automatic sq_stage_t sq_step(input sq_stage_t s);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+2:0] sub;
    logic             ge;
    sq_stage_t        n;
    cur   = {s.rem, s.xs[WIDE_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    sub   = {1'b0, cur} - {1'b0, trial};
    ge    = ~sub[REM_W+2];
    n.rem  = ge ? sub[REM_W-1:0] : cur[REM_W-1:0];
    n.root = {s.root[DATA_W-2:0], ge};
    n.xs   = {s.xs[WIDE_W-3:0], 2'b00};
    return n;
  endfunction

  // Stage chain; the first stage starts from an empty remainder and root.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= sq_step('{rem: '0, root: '0, xs: x_i});
      for (int k = 1; k < SQRT_STAGES; k++) begin
        stage_q[k] <= sq_step(stage_q[k-1]);
      end
    end
  end

  assign root_o = stage_q[SQRT_STAGES-1].root;

endmodule

// ----- hw/rtl/rmj_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider giving the QUO_W-bit quotient of num/den,
// with a flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module rmj_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [NW-1:0]              num_i,
  input  logic [DW-1:0]              den_i,
  output logic [rmj_pkg::QUO_W-1:0]  quo_o,
  output logic                       ovf_o
);
  import rmj_pkg::*;

  localparam int HW = NW - QUO_W;
  localparam int CW = (HW > DW) ? HW : DW;

  typedef struct packed {
    logic [DW-1:0]    rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [DW-1:0]    den;
    logic             ovf;
  } dv_stage_t;

  dv_stage_t stage_q [QUO_W+1];

  logic [CW-1:0] hi_c, den_c;
  dv_stage_t     init_d;

  // Entry stage: the quotient overflows when the upper numerator part
  // already reaches the divisor; otherwise it seeds the remainder.
  always_comb begin
    hi_c       = CW'(num_i[NW-1:QUO_W]);
    den_c      = CW'(den_i);
    init_d.rem = hi_c[DW-1:0];
    init_d.low = num_i[QUO_W-1:0];
    init_d.quo = '0;
    init_d.den = den_i;
    init_d.ovf = (hi_c >= den_c);
  end

  // One quotient bit per stage.
  function automatic dv_stage_t dv_step(input dv_stage_t s);
    logic [DW:0]   ext;
    logic [DW+1:0] sub;
    logic          ge;
    dv_stage_t     n;
    ext   = {s.rem, s.low[QUO_W-1]};
    sub   = {1'b0, ext} - {2'b00, s.den};
    ge    = ~sub[DW+1];
    n     = s;
    n.rem = ge ? sub[DW-1:0] : ext[DW-1:0];
    n.low = {s.low[QUO_W-2:0], 1'b0};
    n.quo = {s.quo[QUO_W-2:0], ge};
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= init_d;
      for (int k = 1; k <= QUO_W; k++) begin
        stage_q[k] <= dv_step(stage_q[k-1]);
      end
    end
  end

  assign quo_o = stage_q[QUO_W].quo;
  assign ovf_o = stage_q[QUO_W].ovf;

endmodule

// ----- hw/rtl/radar_measurement_jacobian_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core
// Radar measurement Jacobian of a 2D constant-velocity state, fixed point.
// ----------------------------------------------------------------------------
// The core takes one state item per clock while the result channel does not
// stall and returns one result item per state, passing through the 32-stage
// square root followed by the 35-stage dividers and the output register. A stall
// on the result channel freezes the whole pipeline, so ready on the input
// follows ready on the output in the same cycle whenever a result is waiting.
// The configuration register may be written at any time and is always ready;
// it should only change while no item is in flight.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmj_in_if.sink    item_i,
  rmj_out_if.source result_o,
  rmj_cfg_if.sink   cfg_i
);
  import rmj_pkg::*;

  localparam int F        = FRAC_BITS;
  localparam int DL       = QUO_W + 1;
  localparam int LAT      = 2 + SQRT_STAGES + 2 + DL + 1;
  localparam int SIDE_DLY = SQRT_STAGES + 2 + DL;
  localparam int N0W      = DATA_W + 1 + F;
  localparam int N2W      = DATA_W + 1 + 2 * F;
  localparam int N4W      = PROD_W + 1 + F;
  localparam logic [DATA_W-1:0] MIN_RANGE_RESET = DATA_W'(66);
  localparam logic signed [DATA_W-1:0] UNIT_POS = DATA_W'(1) << F;
  localparam logic signed [DATA_W-1:0] UNIT_NEG = -UNIT_POS;

  // Round to nearest (ties away from zero), apply sign and saturate.
  function automatic logic [DATA_W-1:0] sat_round(input logic neg, input logic ovf,
                                                  input logic [QUO_W-1:0] t);
    logic [QUO_W:0]   sum;
    logic [QUO_W-1:0] q;
    logic             big;
    sum = {1'b0, t} + {{QUO_W{1'b0}}, 1'b1};
    q   = sum[QUO_W:1];
    big = ovf | (|q[QUO_W-1:DATA_W-1]);
    if (big) begin
      return neg ? SAT_MIN : SAT_MAX;
    end
    return neg ? (~q[DATA_W-1:0] + DATA_W'(1)) : q[DATA_W-1:0];
  endfunction

  // Configuration register.
  logic [DATA_W-1:0] min_range_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= MIN_RANGE_RESET;
    end else if (cfg_i.valid) begin
      min_range_q <= cfg_i.data;
    end
  end

  // Pipeline advance and valid chain.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en           = ~vld_q[LAT-1] | result_o.ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], item_i.valid};
    end
  end

  // Stage 1: magnitudes, squares and velocity cross products.
  logic [DATA_W-1:0]        apx_d, apy_d, apx_q1, apy_q1;
  logic [WIDE_W-1:0]        sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [WIDE_W-1:0] crs_a_d, crs_b_d, crs_a_q, crs_b_q;
  logic                     pxn_q1, pyn_q1;

  assign apx_d   = item_i.pos_x[DATA_W-1] ? (~item_i.pos_x + DATA_W'(1)) : item_i.pos_x;
  assign apy_d   = item_i.pos_y[DATA_W-1] ? (~item_i.pos_y + DATA_W'(1)) : item_i.pos_y;
  assign sqx_d   = apx_d * apx_d;
  assign sqy_d   = apy_d * apy_d;
  assign crs_a_d = item_i.vel_x * item_i.pos_y;
  assign crs_b_d = item_i.vel_y * item_i.pos_x;

  always_ff @(posedge clk_i) begin
    if (en) begin
      apx_q1  <= apx_d;
      apy_q1  <= apy_d;
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      crs_a_q <= crs_a_d;
      crs_b_q <= crs_b_d;
      pxn_q1  <= item_i.pos_x[DATA_W-1];
      pyn_q1  <= item_i.pos_y[DATA_W-1];
    end
  end

  // Stage 2: squared range, cross term magnitude and the range test.
  logic [WIDE_W-1:0] r2_d, r2_q2, adiff_d, adiff_q2, thr;
  logic [WIDE_W:0]   diff_d;
  logic [DATA_W-1:0] apx_q2, apy_q2;
  logic [3:0]        side_d, side_q2, side_out;

  assign r2_d    = sqx_q + sqy_q;
  assign diff_d  = {crs_a_q[WIDE_W-1], crs_a_q} - {crs_b_q[WIDE_W-1], crs_b_q};
  assign adiff_d = diff_d[WIDE_W] ? (~diff_d[WIDE_W-1:0] + WIDE_W'(1)) : diff_d[WIDE_W-1:0];
  assign thr     = {{(WIDE_W-DATA_W-F){1'b0}}, min_range_q, {F{1'b0}}};
  // Side bits: x negative, y negative, cross term negative, below range.
  assign side_d  = {pxn_q1, pyn_q1, diff_d[WIDE_W], (r2_d == '0) | (r2_d < thr)};

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q2    <= r2_d;
      adiff_q2 <= adiff_d;
      apx_q2   <= apx_q1;
      apy_q2   <= apy_q1;
      side_q2  <= side_d;
    end
  end

  // Square root, cube of the range and numerator products.
  logic [DATA_W-1:0]   rq_34, rq_36, apx_36, apy_36;
  logic [WIDE_W-1:0]   r2_34, r2_36;
  logic [PROD_W-1:0]   r3_36, ax_4, ay_4, ax_36, ay_36;

  rmj_isqrt u_sqrt (.clk_i(clk_i), .en_i(en), .x_i(r2_q2), .root_o(rq_34));

  rmj_dly #(.W(WIDE_W), .N(SQRT_STAGES)) u_r2_dly_a (
    .clk_i(clk_i), .en_i(en), .data_i(r2_q2), .data_o(r2_34));
  rmj_dly #(.W(WIDE_W), .N(2)) u_r2_dly_b (
    .clk_i(clk_i), .en_i(en), .data_i(r2_34), .data_o(r2_36));
  rmj_dly #(.W(DATA_W), .N(2)) u_rq_dly (
    .clk_i(clk_i), .en_i(en), .data_i(rq_34), .data_o(rq_36));
  rmj_dly #(.W(2*DATA_W), .N(SQRT_STAGES+2)) u_pos_dly (
    .clk_i(clk_i), .en_i(en), .data_i({apx_q2, apy_q2}), .data_o({apx_36, apy_36}));

  rmj_wmul u_r3_mul (.clk_i(clk_i), .en_i(en), .a_i(r2_34), .b_i(rq_34), .p_o(r3_36));
  rmj_wmul u_ax_mul (.clk_i(clk_i), .en_i(en), .a_i(adiff_q2), .b_i(apx_q2), .p_o(ax_4));
  rmj_wmul u_ay_mul (.clk_i(clk_i), .en_i(en), .a_i(adiff_q2), .b_i(apy_q2), .p_o(ay_4));

  rmj_dly #(.W(2*PROD_W), .N(SQRT_STAGES)) u_prod_dly (
    .clk_i(clk_i), .en_i(en), .data_i({ax_4, ay_4}), .data_o({ax_36, ay_36}));

  rmj_dly #(.W(4), .N(SIDE_DLY)) u_side_dly (
    .clk_i(clk_i), .en_i(en), .data_i(side_q2), .data_o(side_out));

  // Six dividers; numerators are doubled so the last quotient bit rounds.
  logic [QUO_W-1:0] quo [6];
  logic [5:0]       ovf;

  rmj_div #(.NW(N0W), .DW(DATA_W)) u_div_rdx (
    .clk_i(clk_i), .en_i(en), .num_i({apx_36, {(F+1){1'b0}}}), .den_i(rq_36),
    .quo_o(quo[0]), .ovf_o(ovf[0]));
  rmj_div #(.NW(N0W), .DW(DATA_W)) u_div_rdy (
    .clk_i(clk_i), .en_i(en), .num_i({apy_36, {(F+1){1'b0}}}), .den_i(rq_36),
    .quo_o(quo[1]), .ovf_o(ovf[1]));
  rmj_div #(.NW(N2W), .DW(WIDE_W)) u_div_bdx (
    .clk_i(clk_i), .en_i(en), .num_i({apy_36, {(2*F+1){1'b0}}}), .den_i(r2_36),
    .quo_o(quo[2]), .ovf_o(ovf[2]));
  rmj_div #(.NW(N2W), .DW(WIDE_W)) u_div_bdy (
    .clk_i(clk_i), .en_i(en), .num_i({apx_36, {(2*F+1){1'b0}}}), .den_i(r2_36),
    .quo_o(quo[3]), .ovf_o(ovf[3]));
  rmj_div #(.NW(N4W), .DW(PROD_W)) u_div_tdx (
    .clk_i(clk_i), .en_i(en), .num_i({ay_36, {(F+1){1'b0}}}), .den_i(r3_36),
    .quo_o(quo[4]), .ovf_o(ovf[4]));
  rmj_div #(.NW(N4W), .DW(PROD_W)) u_div_tdy (
    .clk_i(clk_i), .en_i(en), .num_i({ax_36, {(F+1){1'b0}}}), .den_i(r3_36),
    .quo_o(quo[5]), .ovf_o(ovf[5]));

  // Output stage: signs, rounding, saturation and the below-range blanking.
  logic              pxn, pyn, dn, low_rng;
  logic [DATA_W-1:0] ent_d [6];
  logic [DATA_W-1:0] ent_q [6];
  logic              vres_q;

  assign {pxn, pyn, dn, low_rng} = side_out;

  always_comb begin
    ent_d[0] = sat_round(pxn, ovf[0], quo[0]);
    ent_d[1] = sat_round(pyn, ovf[1], quo[1]);
    ent_d[2] = sat_round(~pyn, ovf[2], quo[2]);
    ent_d[3] = sat_round(pxn, ovf[3], quo[3]);
    ent_d[4] = sat_round(pyn ^ dn, ovf[4], quo[4]);
    ent_d[5] = sat_round(pxn ^ ~dn, ovf[5], quo[5]);
    if (low_rng) begin
      for (int k = 0; k < 6; k++) begin
        ent_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q  <= ent_d;
      vres_q <= ~low_rng;
    end
  end

  assign result_o.valid      = vld_q[LAT-1];
  assign result_o.range_dx   = ent_q[0];
  assign result_o.range_dy   = ent_q[1];
  assign result_o.bearing_dx = ent_q[2];
  assign result_o.bearing_dy = ent_q[3];
  assign result_o.rate_dx    = ent_q[4];
  assign result_o.rate_dy    = ent_q[5];
  assign result_o.valid_res  = vres_q;

`ifndef SYNTHESIS
  // A result below the range threshold carries only zero entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.valid_res) |->
      (result_o.range_dx == '0 && result_o.range_dy == '0 &&
       result_o.bearing_dx == '0 && result_o.bearing_dy == '0 &&
       result_o.rate_dx == '0 && result_o.rate_dy == '0))
    else $error("below-range result has nonzero entries");

  // A waiting result that is not taken must hold the input side back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |-> !item_i.ready)
    else $error("input accepted while the pipeline is stalled");

  // A position over the floored range never exceeds one in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.valid_res) |->
      (result_o.range_dx <= UNIT_POS && result_o.range_dx >= UNIT_NEG &&
       result_o.range_dy <= UNIT_POS && result_o.range_dy >= UNIT_NEG))
    else $error("range derivative outside unit magnitude");
`endif

endmodule

// ----- test/radar_measurement_jacobian_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core_tb
// Self-checking bench for the radar measurement Jacobian core.
// A clocked driver feeds state items from a queue, a clocked monitor checks
// every result against a local fixed-point predictor of the six Jacobian
// entries. The run passes through several minimum range settings, with
// random idling on both channels and a quiet closing phase.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_core_tb;
  import rmj_pkg::*;

  localparam int FRAC       = 16;
  localparam int MAX_CYCLES = 2000000;
  localparam int DRAIN      = 100;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
  } cv_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_dx;
    logic signed [DATA_W-1:0] range_dy;
    logic signed [DATA_W-1:0] bearing_dx;
    logic signed [DATA_W-1:0] bearing_dy;
    logic signed [DATA_W-1:0] rate_dx;
    logic signed [DATA_W-1:0] rate_dy;
    logic                     valid_res;
  } jacobian_t;

  logic clk_i;
  logic rst_ni;

  rmj_in_if  state_ch ();
  rmj_out_if jac_ch ();
  rmj_cfg_if cfg_ch ();

  radar_measurement_jacobian_core #(.FRAC_BITS(FRAC)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (state_ch.sink),
    .result_o(jac_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  cv_state_t   pending_states[$];
  jacobian_t   expected_jacobians[$];
  logic [31:0] min_range_sq;
  logic        quiet;
  int          send_gap;
  int          stall_gap;
  int          error_count;
  int          checked_count;
  int          invalid_count;
  int          cycle_count;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Magnitude of n / d rounded half away from zero, capped at 2^32.
  function automatic logic [32:0] round_quotient(logic [127:0] n, logic [127:0] d);
    logic [127:0] q;
    logic [128:0] rem2;
    if (d == 0) return 33'h1_0000_0000;
    q    = n / d;
    rem2 = {1'b0, n % d} << 1;
    if (rem2 >= {1'b0, d}) q = q + 1;
    if (q > 128'h1_0000_0000) return 33'h1_0000_0000;
    return q[32:0];
  endfunction

  // Apply the sign and clamp to the 32-bit signed range.
  function automatic logic [31:0] clamp_signed(logic neg, logic [32:0] mag);
    if (neg) return (mag >= 33'h0_8000_0000) ? SAT_MIN : 32'(-mag);
    return (mag > 33'h0_7FFF_FFFF) ? SAT_MAX : mag[31:0];
  endfunction

  // Expected Jacobian entries of one state under the given threshold.
  function automatic jacobian_t predict_jacobian(cv_state_t s, logic [31:0] min_r2);
    jacobian_t              j;
    logic signed [63:0]     spx;
    logic signed [63:0]     spy;
    logic [63:0]            apx;
    logic [63:0]            apy;
    logic [63:0]            r2;
    logic [63:0]            rq;
    logic [63:0]            adiff;
    logic [127:0]           r3;
    logic signed [64:0]     diff;
    j   = '0;
    spx = s.px;
    spy = s.py;
    apx = (spx < 0) ? -spx : spx;
    apy = (spy < 0) ? -spy : spy;
    r2  = apx * apx + apy * apy;
    if (r2 == 0 || r2 < ({32'd0, min_r2} << FRAC)) return j;
    rq    = floor_sqrt(r2);
    r3    = 128'(r2) * 128'(rq);
    diff  = s.vx * s.py - s.vy * s.px;
    adiff = (diff < 0) ? 64'(-diff) : 64'(diff);
    j.range_dx   = clamp_signed(s.px < 0, round_quotient(128'(apx) << FRAC, 128'(rq)));
    j.range_dy   = clamp_signed(s.py < 0, round_quotient(128'(apy) << FRAC, 128'(rq)));
    j.bearing_dx = clamp_signed(s.py > 0, round_quotient(128'(apy) << (2 * FRAC), 128'(r2)));
    j.bearing_dy = clamp_signed(s.px < 0, round_quotient(128'(apx) << (2 * FRAC), 128'(r2)));
    j.rate_dx    = clamp_signed((s.py < 0) != (diff < 0),
                                round_quotient((128'(apy) * 128'(adiff)) << FRAC, r3));
    j.rate_dy    = clamp_signed((s.px < 0) != (diff > 0),
                                round_quotient((128'(apx) * 128'(adiff)) << FRAC, r3));
    j.valid_res  = 1'b1;
    return j;
  endfunction

  // Random field: full range, or shifted down to reach small ranges.
  function automatic logic signed [31:0] random_field();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) < 4) v = v >>> $urandom_range(0, 31);
    return v;
  endfunction

  // Driver: holds an item until accepted, predicts it at acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    cv_state_t s;
    if (!rst_ni) begin
      state_ch.valid <= 1'b0;
      state_ch.pos_x <= '0;
      state_ch.pos_y <= '0;
      state_ch.vel_x <= '0;
      state_ch.vel_y <= '0;
      send_gap       <= 0;
    end else begin
      if (state_ch.valid && state_ch.ready) begin
        s = {state_ch.pos_x, state_ch.pos_y, state_ch.vel_x, state_ch.vel_y};
        expected_jacobians.push_back(predict_jacobian(s, min_range_sq));
      end
      if (state_ch.valid && !state_ch.ready) begin
        // Hold the current item.
      end else if (send_gap > 0) begin
        send_gap       <= send_gap - 1;
        state_ch.valid <= 1'b0;
      end else if (pending_states.size() == 0) begin
        state_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        send_gap       <= $urandom_range(0, 11);
        state_ch.valid <= 1'b0;
      end else begin
        s = pending_states.pop_front();
        state_ch.valid <= 1'b1;
        state_ch.pos_x <= s.px;
        state_ch.pos_y <= s.py;
        state_ch.vel_x <= s.vx;
        state_ch.vel_y <= s.vy;
      end
    end
  end

  // Monitor: stalls in bursts and checks every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    jacobian_t got;
    jacobian_t want;
    if (!rst_ni) begin
      jac_ch.ready <= 1'b0;
      stall_gap    <= 0;
    end else begin
      if (jac_ch.valid && jac_ch.ready) begin
        got = {jac_ch.range_dx, jac_ch.range_dy, jac_ch.bearing_dx, jac_ch.bearing_dy,
               jac_ch.rate_dx, jac_ch.rate_dy, jac_ch.valid_res};
        if (expected_jacobians.size() == 0) begin
          $display("%0t: unexpected result item %h", $realtime, got);
          error_count = error_count + 1;
        end else begin
          want = expected_jacobians.pop_front();
          checked_count = checked_count + 1;
          if (!want.valid_res) invalid_count = invalid_count + 1;
          if (got.range_dx !== want.range_dx)
            $display("%0t: range_dx expected %h actual %h", $realtime, want.range_dx,
                     got.range_dx);
          if (got.range_dy !== want.range_dy)
            $display("%0t: range_dy expected %h actual %h", $realtime, want.range_dy,
                     got.range_dy);
          if (got.bearing_dx !== want.bearing_dx)
            $display("%0t: bearing_dx expected %h actual %h", $realtime, want.bearing_dx,
                     got.bearing_dx);
          if (got.bearing_dy !== want.bearing_dy)
            $display("%0t: bearing_dy expected %h actual %h", $realtime, want.bearing_dy,
                     got.bearing_dy);
          if (got.rate_dx !== want.rate_dx)
            $display("%0t: rate_dx expected %h actual %h", $realtime, want.rate_dx,
                     got.rate_dx);
          if (got.rate_dy !== want.rate_dy)
            $display("%0t: rate_dy expected %h actual %h", $realtime, want.rate_dy,
                     got.rate_dy);
          if (got.valid_res !== want.valid_res)
            $display("%0t: valid_res expected %b actual %b", $realtime, want.valid_res,
                     got.valid_res);
          if (got !== want) error_count = error_count + 1;
        end
      end
      if (stall_gap > 0) begin
        stall_gap    <= stall_gap - 1;
        jac_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_gap    <= $urandom_range(0, 11);
        jac_ch.ready <= 1'b0;
      end else begin
        jac_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Wait until the driver has sent everything and every result has come.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_states.size() != 0 || state_ch.valid ||
               expected_jacobians.size() != 0);
  endtask

  // Write the minimum squared range while no item is in flight.
  task automatic write_min_range(logic [31:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    min_range_sq = value;
  endtask

  task automatic add_state(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                           logic [31:0] vy);
    cv_state_t s;
    s = {px, py, vx, vy};
    pending_states.push_back(s);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_state(random_field(), random_field(), random_field(), random_field());
  endtask

  // Stimulus.
  initial begin
    rst_ni         = 1'b0;
    state_ch.valid = 1'b0;
    state_ch.pos_x = '0;
    state_ch.pos_y = '0;
    state_ch.vel_x = '0;
    state_ch.vel_y = '0;
    jac_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    min_range_sq   = 32'd66;
    quiet          = 1'b0;
    error_count    = 0;
    checked_count  = 0;
    invalid_count  = 0;
    cycle_count    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni = 1'b1;

    // Reset threshold: zero range, tiny range, just around the threshold,
    // field extremes and saturating rate terms.
    add_state(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_state(32'd1, 32'd0, 32'd0, 32'd0);
    add_state(32'd2079, 32'd0, 32'd5, 32'd7);
    add_state(32'd2080, 32'd0, 32'd5, 32'd7);
    add_state(32'd0, -32'sd2080, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_state(32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF);
    add_state(32'd3000, -32'sd3000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_state(-32'sd2100, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF);
    add_state(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, -32'sh0001_0000);
    add_random(380);
    wait_idle();

    // Zero threshold: only a zero range is invalid, small ranges saturate.
    write_min_range(32'd0);
    add_state(32'd0, 32'd0, 32'd1, 32'd1);
    add_state(32'd1, 32'd0, 32'd0, 32'd0);
    add_state(32'd0, -32'sd1, 32'd0, 32'd0);
    add_state(-32'sd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_state(32'd3, 32'd4, 32'h8000_0000, 32'h8000_0000);
    add_random(380);
    wait_idle();

    // Largest threshold: most small states are rejected.
    write_min_range(32'hFFFF_FFFF);
    add_state(32'h7FFF_FFFF, 32'd0, 32'd1, 32'd1);
    add_state(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    add_random(380);
    wait_idle();

    write_min_range($urandom);
    add_random(380);
    wait_idle();

    // Back to the reset value with both sides running flat out.
    write_min_range(32'd66);
    quiet = 1'b1;
    add_random(400);
    wait_idle();
    repeat (DRAIN) @(posedge clk_i);

    $display("Checked %0d result items, %0d below the range threshold, over five",
             checked_count, invalid_count);
    $display("threshold settings including zero and the largest value.");
    if (error_count == 0 && expected_jacobians.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- radar_measurement_jacobian_core.f -----
hw/rtl/rmj_pkg.sv
hw/rtl/rmj_in_if.sv
hw/rtl/rmj_out_if.sv
hw/rtl/rmj_cfg_if.sv
hw/rtl/rmj_dly.sv
hw/rtl/rmj_wmul.sv
hw/rtl/rmj_isqrt.sv
hw/rtl/rmj_div.sv
hw/rtl/radar_measurement_jacobian_core.sv
test/radar_measurement_jacobian_core_tb.sv
